[hdl/orthonormal_basis_builder_top_defines.svh]
// orthonormal_basis_builder_top_defines.svh
// Assertion macros for the basis builder; expect clk_i and rst_ni in scope.
// Define SYNTH to compile them out.
`ifndef ORTHONORMAL_BASIS_BUILDER_TOP_DEFINES_SVH
`define ORTHONORMAL_BASIS_BUILDER_TOP_DEFINES_SVH
`ifndef SYNTH
`define OBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define OBB_ASSERT(lbl, prop, msg)
`define OBB_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hdl/obb_pkg.sv]
// obb_pkg.sv
// Shared constants, mode codes and axis lookup functions of the basis builder.
// No dependencies.
package obb_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_W         = 16;
  localparam int THR_W         = 29;
  localparam int FUNC_W        = 4;
  localparam logic [THR_W-1:0] THR_RESET = 29'd2684355;

  typedef enum logic [FUNC_W-1:0] {
    FN_U  = 4'd0,
    FN_V  = 4'd1,
    FN_W  = 4'd2,
    FN_UV = 4'd3,
    FN_VU = 4'd4,
    FN_UW = 4'd5,
    FN_WU = 4'd6,
    FN_VW = 4'd7,
    FN_WV = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    AX_U = 2'd0,
    AX_V = 2'd1,
    AX_W = 2'd2
  } axis_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              ok;
  } ctl_t;

  function automatic axis_e first_axis(logic [FUNC_W-1:0] f);
    axis_e ax;
    case (f)
      FN_U, FN_UV, FN_UW: ax = AX_U;
      FN_V, FN_VU, FN_VW: ax = AX_V;
      default:            ax = AX_W;
    endcase
    return ax;
  endfunction

  function automatic axis_e second_axis(logic [FUNC_W-1:0] f);
    axis_e ax;
    case (f)
      FN_U:         ax = AX_V;
      FN_V, FN_W:   ax = AX_U;
      FN_UV, FN_VU: ax = AX_W;
      FN_UW, FN_WU: ax = AX_V;
      FN_VW, FN_WV: ax = AX_U;
      default:      ax = AX_V;
    endcase
    return ax;
  endfunction

  function automatic axis_e third_axis(axis_e p, axis_e q);
    axis_e ax;
    if (p != AX_U && q != AX_U) begin
      ax = AX_U;
    end else if (p != AX_V && q != AX_V) begin
      ax = AX_V;
    end else begin
      ax = AX_W;
    end
    return ax;
  endfunction

  // second axis built from b x a instead of a x b
  function automatic logic is_swap(logic [FUNC_W-1:0] f);
    logic s;
    case (f)
      FN_VU, FN_UW, FN_WV: s = 1'b1;
      default:             s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

[hdl/obb_ifs.sv]
// obb_ifs.sv
// Request, result and configuration channels of the basis builder.
// Depends on obb_pkg.
interface obb_req_if #(
  parameter int IN_WIDTH = obb_pkg::IN_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic [obb_pkg::FUNC_W-1:0]          func;
  logic signed [IN_WIDTH-1:0]          first_x;
  logic signed [IN_WIDTH-1:0]          first_y;
  logic signed [IN_WIDTH-1:0]          first_z;
  logic signed [IN_WIDTH-1:0]          second_x;
  logic signed [IN_WIDTH-1:0]          second_y;
  logic signed [IN_WIDTH-1:0]          second_z;

  modport source (output valid, func, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink (input valid, func, first_x, first_y, first_z,
                second_x, second_y, second_z, output ready);
endinterface

interface obb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [obb_pkg::OUT_W-1:0]  u_x;
  logic signed [obb_pkg::OUT_W-1:0]  u_y;
  logic signed [obb_pkg::OUT_W-1:0]  u_z;
  logic signed [obb_pkg::OUT_W-1:0]  v_x;
  logic signed [obb_pkg::OUT_W-1:0]  v_y;
  logic signed [obb_pkg::OUT_W-1:0]  v_z;
  logic signed [obb_pkg::OUT_W-1:0]  w_x;
  logic signed [obb_pkg::OUT_W-1:0]  w_y;
  logic signed [obb_pkg::OUT_W-1:0]  w_z;
  logic                              degenerate;

  modport source (output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
                  degenerate, input ready);
  modport sink (input valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z,
                degenerate, output ready);
endinterface

interface obb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [obb_pkg::THR_W-1:0]  parallel_threshold;

  modport source (output valid, parallel_threshold, input ready);
  modport sink (input valid, parallel_threshold, output ready);
endinterface

[hdl/orthonormal_basis_builder_top.sv]
// orthonormal_basis_builder_top.sv
// Top level: two normalizers around the second-axis stage, third axis and output register.
// Depends on obb_pkg, obb_ifs, obb_norm, obb_second and the defines header.
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    func, first_x..z, second_x..z
//  cfg_i    in   valid/ready    parallel_threshold
//  rsp_o    out  valid/ready    u_x..w_z, degenerate
//
// One request per cycle while the pipeline is not held; each of the two normalizers
// has a 32-stage square root and a FRAC_BITS+1-stage divider.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears valid bits and loads the threshold; cfg writes are always ready.
`include "orthonormal_basis_builder_top_defines.svh"

module orthonormal_basis_builder_top #(
  parameter int IN_WIDTH  = obb_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  obb_req_if.sink    req_i,
  obb_cfg_if.sink    cfg_i,
  obb_rsp_if.source  rsp_o
);

  localparam int AW  = FRAC_BITS + 2;
  localparam int CW2 = (2 * IN_WIDTH + 2 > AW + 1) ? 2 * IN_WIDTH + 2 : AW + 1;
  localparam int CTW = $bits(obb_pkg::ctl_t);
  localparam int SW1 = obb_pkg::FUNC_W + 6 * IN_WIDTH;
  localparam int SW2 = CTW + 3 * AW;
  localparam int XW  = 2 * AW + 1;
  localparam int OW  = obb_pkg::OUT_W;

  logic en;
  logic out_v_q;

  assign en          = !out_v_q || rsp_o.ready;
  assign req_i.ready = en;
  assign cfg_i.ready = 1'b1;

  logic [obb_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= obb_pkg::THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.parallel_threshold;
    end
  end

  // first axis
  logic signed [IN_WIDTH-1:0] a_in [3];
  logic [SW1-1:0]             side1_in;
  logic                       n1_v;
  logic                       n1_zero;
  logic signed [AW-1:0]       n1_p [3];
  logic [SW1-1:0]             n1_side;

  assign a_in[0]  = req_i.first_x;
  assign a_in[1]  = req_i.first_y;
  assign a_in[2]  = req_i.first_z;
  assign side1_in = {req_i.func, req_i.second_z, req_i.second_y, req_i.second_x,
                     req_i.first_z, req_i.first_y, req_i.first_x};

  obb_norm #(
    .CW        (IN_WIDTH),
    .SW        (SW1),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .comp_i  (a_in),
    .side_i  (side1_in),
    .valid_o (n1_v),
    .zero_o  (n1_zero),
    .comp_o  (n1_p),
    .side_o  (n1_side)
  );

  // second-axis source vector
  logic signed [IN_WIDTH-1:0] n1_a [3];
  logic signed [IN_WIDTH-1:0] n1_b [3];
  obb_pkg::ctl_t              n1_ctl;
  logic                       s_v;
  obb_pkg::ctl_t              s_ctl;
  logic signed [AW-1:0]       s_p   [3];
  logic signed [CW2-1:0]      s_tmp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_a[i] = n1_side[i*IN_WIDTH +: IN_WIDTH];
      n1_b[i] = n1_side[(3+i)*IN_WIDTH +: IN_WIDTH];
    end
    n1_ctl.func = n1_side[6*IN_WIDTH +: obb_pkg::FUNC_W];
    n1_ctl.ok   = !n1_zero && (n1_ctl.func <= obb_pkg::FN_WV);
  end

  obb_second #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n1_v),
    .ctl_i   (n1_ctl),
    .a_i     (n1_a),
    .b_i     (n1_b),
    .p_i     (n1_p),
    .thr_i   (thr_q),
    .valid_o (s_v),
    .ctl_o   (s_ctl),
    .p_o     (s_p),
    .tmp_o   (s_tmp)
  );

  // second axis
  logic [SW2-1:0]        side2_in;
  logic                  n2_v;
  logic                  n2_zero;
  logic signed [AW-1:0]  n2_q [3];
  logic [SW2-1:0]        n2_side;

  assign side2_in = {s_ctl, s_p[2], s_p[1], s_p[0]};

  obb_norm #(
    .CW        (CW2),
    .SW        (SW2),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_v),
    .comp_i  (s_tmp),
    .side_i  (side2_in),
    .valid_o (n2_v),
    .zero_o  (n2_zero),
    .comp_o  (n2_q),
    .side_o  (n2_side)
  );

  // third axis: operand select and products
  obb_pkg::ctl_t         n2_ctl;
  obb_pkg::axis_e        p_ax;
  obb_pkg::axis_e        q_ax;
  obb_pkg::axis_e        r_ax;
  logic signed [AW-1:0]  n2_p  [3];
  logic signed [AW-1:0]  ax_d  [3][3];
  logic signed [AW-1:0]  opa   [3];
  logic signed [AW-1:0]  opb   [3];

  always_comb begin
    n2_ctl = n2_side[3*AW +: CTW];
    for (int i = 0; i < 3; i++) begin
      n2_p[i] = n2_side[i*AW +: AW];
    end
    p_ax = obb_pkg::first_axis(n2_ctl.func);
    q_ax = obb_pkg::second_axis(n2_ctl.func);
    r_ax = obb_pkg::third_axis(p_ax, q_ax);
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (i == int'(p_ax)) begin
          ax_d[i][c] = n2_p[c];
        end else if (i == int'(q_ax)) begin
          ax_d[i][c] = n2_q[c];
        end else begin
          ax_d[i][c] = '0;
        end
      end
    end
    case (r_ax)
      obb_pkg::AX_U: begin
        opa = ax_d[obb_pkg::AX_V];
        opb = ax_d[obb_pkg::AX_W];
      end
      obb_pkg::AX_V: begin
        opa = ax_d[obb_pkg::AX_W];
        opb = ax_d[obb_pkg::AX_U];
      end
      default: begin
        opa = ax_d[obb_pkg::AX_U];
        opb = ax_d[obb_pkg::AX_V];
      end
    endcase
  end

  logic                        t_v_q;
  logic                        t_ok_q;
  logic [obb_pkg::FUNC_W-1:0]  t_func_q;
  obb_pkg::axis_e              t_r_q;
  logic signed [AW-1:0]        t_ax_q [3][3];
  logic signed [2*AW-1:0]      t_pr_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= n2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_ok_q    <= n2_ctl.ok && !n2_zero;
      t_func_q  <= n2_ctl.func;
      t_r_q     <= r_ax;
      t_ax_q    <= ax_d;
      t_pr_q[0] <= (2*AW)'(opa[1]) * (2*AW)'(opb[2]);
      t_pr_q[1] <= (2*AW)'(opa[2]) * (2*AW)'(opb[1]);
      t_pr_q[2] <= (2*AW)'(opa[2]) * (2*AW)'(opb[0]);
      t_pr_q[3] <= (2*AW)'(opa[0]) * (2*AW)'(opb[2]);
      t_pr_q[4] <= (2*AW)'(opa[0]) * (2*AW)'(opb[1]);
      t_pr_q[5] <= (2*AW)'(opa[1]) * (2*AW)'(opb[0]);
    end
  end

  // round, clamp, place the axes
  logic signed [XW-1:0]  crs  [3];
  logic [XW-1:0]         cmag [3];
  logic [XW-1:0]         crnd [3];
  logic [AW-1:0]         cval [3];
  logic signed [OW-1:0]  out_d [3][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      crs[c]  = XW'(t_pr_q[2*c]) - XW'(t_pr_q[2*c+1]);
      cmag[c] = crs[c][XW-1] ? (~crs[c] + XW'(1)) : crs[c];
      crnd[c] = (cmag[c] + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (crnd[c] > (XW'(1) << FRAC_BITS)) begin
        crnd[c] = XW'(1) << FRAC_BITS;
      end
      cval[c] = crs[c][XW-1] ? (~AW'(crnd[c]) + AW'(1)) : AW'(crnd[c]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (!t_ok_q) begin
          out_d[i][c] = '0;
        end else if (i == int'(t_r_q)) begin
          out_d[i][c] = OW'($signed(cval[c]));
        end else begin
          out_d[i][c] = OW'(t_ax_q[i][c]);
        end
      end
    end
  end

  logic signed [OW-1:0]  out_q [3][3];
  logic                  degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q   <= out_d;
      degen_q <= !t_ok_q;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.u_x        = out_q[0][0];
  assign rsp_o.u_y        = out_q[0][1];
  assign rsp_o.u_z        = out_q[0][2];
  assign rsp_o.v_x        = out_q[1][0];
  assign rsp_o.v_y        = out_q[1][1];
  assign rsp_o.v_z        = out_q[1][2];
  assign rsp_o.w_x        = out_q[2][0];
  assign rsp_o.w_y        = out_q[2][1];
  assign rsp_o.w_z        = out_q[2][2];
  assign rsp_o.degenerate = degen_q;

  `OBB_ASSERT_IMP(a_degen_zero, out_v_q && degen_q,
    out_q[0][0] == 0 && out_q[0][1] == 0 && out_q[0][2] == 0 &&
    out_q[1][0] == 0 && out_q[1][1] == 0 && out_q[1][2] == 0 &&
    out_q[2][0] == 0 && out_q[2][1] == 0 && out_q[2][2] == 0,
    "degenerate result with nonzero axis")
  `OBB_ASSERT_IMP(a_bad_func, t_v_q && (t_func_q > obb_pkg::FN_WV), !t_ok_q,
    "undefined mode reached third axis as valid")
  `OBB_ASSERT(a_load_en, $rose(out_v_q) |-> $past(en), "output loaded while stalled")

endmodule

[hdl/obb_norm.sv]
// obb_norm.sv
// Pipelined vector normalizer: align, square, bitwise square root, restoring divide.
// Depends on obb_pkg.
module obb_norm #(
  parameter int CW        = obb_pkg::IN_WIDTH_DEF,
  parameter int SW        = 1,
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF,
  localparam int AW       = FRAC_BITS + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] comp_i [3],
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic                 zero_o,
  output logic signed [AW-1:0] comp_o [3],
  output logic [SW-1:0]        side_o
);

  localparam int MW        = 30;
  localparam int PW        = $clog2(CW);
  localparam int SQW       = 2 * MW;
  localparam int XW        = 64;
  localparam int SQ_STAGES = 32;
  localparam int LW        = 32;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DW        = MW + FRAC_BITS + 2;

  typedef struct packed {
    logic [SW-1:0]          side;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][MW-1:0]     m;
  } car_t;

  typedef struct packed {
    logic [SW-1:0] side;
    logic          zero;
    logic [2:0]    neg;
  } dcar_t;

  // stage 1: magnitudes
  logic           v1_q;
  logic [SW-1:0]  side1_q;
  logic [2:0]     neg1_q;
  logic [CW-1:0]  mag1_d [3];
  logic [CW-1:0]  mag1_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = comp_i[i][CW-1] ? (CW'(~comp_i[i]) + CW'(1)) : CW'(comp_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= comp_i[i][CW-1];
        mag1_q[i] <= mag1_d[i];
      end
    end
  end

  // stage 2: leading one of the largest magnitude
  logic           v2_q;
  logic [SW-1:0]  side2_q;
  logic [2:0]     neg2_q;
  logic           zero2_q;
  logic [CW-1:0]  mag2_q [3];
  logic [CW-1:0]  orv;
  logic [PW-1:0]  pos2_d;
  logic [PW-1:0]  pos2_q;

  always_comb begin
    orv    = mag1_q[0] | mag1_q[1] | mag1_q[2];
    pos2_d = '0;
    for (int b = 0; b < CW; b++) begin
      if (orv[b]) begin
        pos2_d = PW'(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side1_q;
      neg2_q  <= neg1_q;
      zero2_q <= (orv == '0);
      pos2_q  <= pos2_d;
      mag2_q  <= mag1_q;
    end
  end

  // stage 3: align top bit to bit 29
  logic           v3_q;
  car_t           c3_d;
  car_t           c3_q;

  always_comb begin
    int pos_v;
    pos_v     = int'(pos2_q);
    c3_d.side = side2_q;
    c3_d.zero = zero2_q;
    c3_d.neg  = neg2_q;
    for (int i = 0; i < 3; i++) begin
      if (pos_v > MW - 1) begin
        c3_d.m[i] = MW'(mag2_q[i] >> (pos_v - (MW - 1)));
      end else begin
        c3_d.m[i] = MW'({{MW{1'b0}}, mag2_q[i]} << (MW - 1 - pos_v));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q <= c3_d;
    end
  end

  // stage 4: squares
  logic           v4_q;
  car_t           c4_q;
  logic [SQW-1:0] sqr4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_q <= c3_q;
      for (int i = 0; i < 3; i++) begin
        sqr4_q[i] <= SQW'(c3_q.m[i]) * SQW'(c3_q.m[i]);
      end
    end
  end

  // stage 5 and square root, one result bit per stage
  logic           sv_q [SQ_STAGES+1];
  car_t           sc_q [SQ_STAGES+1];
  logic [XW-1:0]  sx_q [SQ_STAGES+1];
  logic [XW-1:0]  sr_q [SQ_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q[0] <= c4_q;
      sx_q[0] <= XW'(sqr4_q[0]) + XW'(sqr4_q[1]) + XW'(sqr4_q[2]);
      sr_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [XW-1:0] sbit;
    logic [XW-1:0] trial;
    logic [XW-1:0] x_d;
    logic [XW-1:0] r_d;

    assign sbit = XW'(1) << (2 * (SQ_STAGES - 1 - k));

    always_comb begin
      trial = sr_q[k] + sbit;
      if (sx_q[k] >= trial) begin
        x_d = sx_q[k] - trial;
        r_d = (sr_q[k] >> 1) + sbit;
      end else begin
        x_d = sx_q[k];
        r_d = sr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sc_q[k+1] <= sc_q[k];
        sx_q[k+1] <= x_d;
        sr_q[k+1] <= r_d;
      end
    end
  end

  // restoring divide, three lanes, one quotient bit per stage
  logic           dv_q   [QW+1];
  dcar_t          dc_q   [QW+1];
  logic [LW-1:0]  dlen_q [QW+1];
  logic [DW-1:0]  drem_q [QW+1][3];
  logic [QW-1:0]  dq_q   [QW+1][3];
  logic [LW-1:0]  len_v;

  assign len_v = LW'(sr_q[SQ_STAGES]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[SQ_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dc_q[0]   <= '{side: sc_q[SQ_STAGES].side, zero: sc_q[SQ_STAGES].zero,
                     neg: sc_q[SQ_STAGES].neg};
      dlen_q[0] <= len_v;
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= (DW'(sc_q[SQ_STAGES].m[i]) << FRAC_BITS) + DW'(len_v >> 1);
        dq_q[0][i]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [DW-1:0] dvs;
    logic [DW-1:0] rem_d [3];
    logic [QW-1:0] q_d   [3];

    assign dvs = DW'(dlen_q[j]) << SH;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (drem_q[j][i] >= dvs) begin
          rem_d[i] = drem_q[j][i] - dvs;
          q_d[i]   = dq_q[j][i] | (QW'(1) << SH);
        end else begin
          rem_d[i] = drem_q[j][i];
          q_d[i]   = dq_q[j][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dc_q[j+1]   <= dc_q[j];
        dlen_q[j+1] <= dlen_q[j];
        drem_q[j+1] <= rem_d;
        dq_q[j+1]   <= q_d;
      end
    end
  end

  // sign and output register
  logic          vo_q;
  logic [AW-1:0] out_d [3];

  always_comb begin
    logic [AW-1:0] qa;
    qa = '0;
    for (int i = 0; i < 3; i++) begin
      qa = AW'(dq_q[QW][i]);
      if (dc_q[QW].zero) begin
        out_d[i] = '0;
      end else if (dc_q[QW].neg[i]) begin
        out_d[i] = ~qa + AW'(1);
      end else begin
        out_d[i] = qa;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_o <= dc_q[QW].zero;
      side_o <= dc_q[QW].side;
      for (int i = 0; i < 3; i++) begin
        comp_o[i] <= out_d[i];
      end
    end
  end

  assign valid_o = vo_q;

endmodule

[hdl/obb_second.sv]
// obb_second.sv
// Raw vector for the second axis: input cross product or axis fallback test.
// Depends on obb_pkg.
module obb_second #(
  parameter int IN_WIDTH  = obb_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF,
  localparam int AW       = FRAC_BITS + 2,
  localparam int CW2      = (2 * IN_WIDTH + 2 > AW + 1) ? 2 * IN_WIDTH + 2 : AW + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  obb_pkg::ctl_t               ctl_i,
  input  logic signed [IN_WIDTH-1:0]  a_i [3],
  input  logic signed [IN_WIDTH-1:0]  b_i [3],
  input  logic signed [AW-1:0]        p_i [3],
  input  logic [obb_pkg::THR_W-1:0]   thr_i,
  output logic                        valid_o,
  output obb_pkg::ctl_t               ctl_o,
  output logic signed [AW-1:0]        p_o [3],
  output logic signed [CW2-1:0]       tmp_o [3]
);

  localparam int PRW  = 2 * IN_WIDTH;
  localparam int SSW  = 2 * AW;
  localparam int CMPW = 2 * AW + 30;
  localparam int SH_T = (2 * FRAC_BITS >= 28) ? 2 * FRAC_BITS - 28 : 0;
  localparam int SH_S = (2 * FRAC_BITS >= 28) ? 0 : 28 - 2 * FRAC_BITS;

  logic                   v1_q;
  obb_pkg::ctl_t          ctl1_q;
  logic signed [AW-1:0]   p1_q  [3];
  logic signed [PRW-1:0]  pab_q [6];
  logic signed [SSW-1:0]  pyy_q;
  logic signed [SSW-1:0]  pzz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q   <= ctl_i;
      p1_q     <= p_i;
      pab_q[0] <= PRW'(a_i[1]) * PRW'(b_i[2]);
      pab_q[1] <= PRW'(a_i[2]) * PRW'(b_i[1]);
      pab_q[2] <= PRW'(a_i[2]) * PRW'(b_i[0]);
      pab_q[3] <= PRW'(a_i[0]) * PRW'(b_i[2]);
      pab_q[4] <= PRW'(a_i[0]) * PRW'(b_i[1]);
      pab_q[5] <= PRW'(a_i[1]) * PRW'(b_i[0]);
      pyy_q    <= SSW'(p_i[1]) * SSW'(p_i[1]);
      pzz_q    <= SSW'(p_i[2]) * SSW'(p_i[2]);
    end
  end

  logic [CMPW-1:0]        sq_v;
  logic [CMPW-1:0]        thr_v;
  logic                   use_x;
  logic signed [CW2-1:0]  crs   [3];
  logic signed [CW2-1:0]  tmp_d [3];

  always_comb begin
    sq_v   = CMPW'(pyy_q) + CMPW'(pzz_q);
    thr_v  = CMPW'(thr_i);
    use_x  = (sq_v << SH_S) >= (thr_v << SH_T);
    crs[0] = CW2'(pab_q[0]) - CW2'(pab_q[1]);
    crs[1] = CW2'(pab_q[2]) - CW2'(pab_q[3]);
    crs[2] = CW2'(pab_q[4]) - CW2'(pab_q[5]);
    if (ctl1_q.func <= obb_pkg::FN_W) begin
      if (use_x) begin
        tmp_d[0] = '0;
        tmp_d[1] = CW2'(p1_q[2]);
        tmp_d[2] = -CW2'(p1_q[1]);
      end else begin
        tmp_d[0] = -CW2'(p1_q[2]);
        tmp_d[1] = '0;
        tmp_d[2] = CW2'(p1_q[0]);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        tmp_d[i] = obb_pkg::is_swap(ctl1_q.func) ? -crs[i] : crs[i];
      end
    end
  end

  logic vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl1_q;
      p_o   <= p1_q;
      tmp_o <= tmp_d;
    end
  end

  assign valid_o = vo_q;

endmodule
